[sv/lfd_pkg.sv]
// Shared types, constants and valve loss tables for the lock flow derivative unit.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

  localparam int FRAC         = 16;
  localparam int TABLE_POINTS = 18;
  localparam int LAST_SEG     = TABLE_POINTS - 1;
  localparam int SEG_W        = $clog2(TABLE_POINTS);

  localparam int REG_W     = 31;
  localparam int REG_IDX_W = 3;
  localparam int LEVEL_W   = 32;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 96;

  localparam int FRONT_STAGES = 2;
  localparam int KV_STAGES    = 5;
  localparam int LOSS_STAGES  = 7;
  localparam int PIPE_STAGES  = FRONT_STAGES + KV_STAGES + LOSS_STAGES;
  localparam int KV_OUT_STAGE = FRONT_STAGES + KV_STAGES - 1;

  localparam int T_PROD_W  = 2 * REG_W;
  localparam int PCT_RAW_W = T_PROD_W - FRAC;
  localparam int PCT_W     = $clog2((100 << FRAC) + 1);
  localparam int MAX_SEG_W = 20;
  localparam int D_W       = $clog2(MAX_SEG_W << (FRAC - 1));
  localparam int DEL_W     = 22;
  localparam int DM_W      = 40;
  localparam int N_W       = 40;
  localparam int X_W       = 37;
  localparam int KV_W      = 30;
  localparam int DRIVE_W   = 64 - FRAC;
  localparam int QQ_W      = 63 - FRAC;
  localparam int LOSS_W    = 63;

  localparam int KV_DIV  = 125;
  localparam int RECIP_W = 31;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER_GAIN    = 3'd0,
    REG_LOWER_GAIN    = 3'd1,
    REG_HEAD_GAIN     = 3'd2,
    REG_PIPE_FRICTION = 3'd3,
    REG_LOSS_SCALE    = 3'd4,
    REG_ENTRY_LOSS    = 3'd5,
    REG_OPENING_RATE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] upper_rate;
    logic [LEVEL_W-1:0] lower_rate;
    logic [DRIVE_W-1:0] drive;
    logic               q_neg;
    logic [QQ_W-1:0]    qq;
  } side_t;

  typedef logic [PCT_W-1:0]        bp_tab_t    [TABLE_POINTS];
  typedef logic signed [N_W-1:0]   base_tab_t  [TABLE_POINTS];
  typedef logic signed [DEL_W-1:0] del_tab_t   [TABLE_POINTS];
  typedef logic [2:0]              shift_tab_t [TABLE_POINTS];

  // breakpoints in half percent, valve loss in hundredths
  localparam int unsigned OPEN_HALF [TABLE_POINTS] = '{
    0, 5, 10, 15, 20, 25, 30, 35, 40, 60, 80, 100, 120, 140, 160, 180, 190, 200};
  localparam longint KV_HUND [TABLE_POINTS] = '{
    1000000, 284000, 73000, 33500, 18500, 11000, 7500, 5500, 4300,
    1700, 800, 400, 200, 100, 50, 26, 17, 11};

  function automatic bp_tab_t build_bp();
    bp_tab_t tab;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      tab[i] = PCT_W'(longint'(OPEN_HALF[i]) << (FRAC - 1));
    end
    return tab;
  endfunction

  // kv_i * w * 2^F plus half the divisor 100 * w
  function automatic base_tab_t build_base();
    base_tab_t tab;
    longint    w;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      if (i < LAST_SEG) begin
        w      = longint'(OPEN_HALF[i+1]) - longint'(OPEN_HALF[i]);
        tab[i] = N_W'(KV_HUND[i] * w * (longint'(1) << FRAC) + 50 * w);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  function automatic del_tab_t build_del();
    del_tab_t tab;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      if (i < LAST_SEG) begin
        tab[i] = DEL_W'(2 * (KV_HUND[i+1] - KV_HUND[i]));
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  // divisor 100*w = 125 * 2^shift
  function automatic shift_tab_t build_shift();
    shift_tab_t tab;
    longint     w;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      if (i < LAST_SEG) begin
        w = longint'(OPEN_HALF[i+1]) - longint'(OPEN_HALF[i]);
        if (w == 20) begin
          tab[i] = 3'd4;
        end else if (w == 10) begin
          tab[i] = 3'd3;
        end else begin
          tab[i] = 3'd2;
        end
      end else begin
        tab[i] = 3'd2;
      end
    end
    return tab;
  endfunction

  localparam bp_tab_t    SEG_BP    = build_bp();
  localparam base_tab_t  SEG_BASE  = build_base();
  localparam del_tab_t   SEG_DEL   = build_del();
  localparam shift_tab_t SEG_SHIFT = build_shift();

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((longint'(1) << X_W) / KV_DIV);
  localparam logic [KV_W-1:0] KV_FULL = KV_W'(((KV_HUND[LAST_SEG] << FRAC) + 50) / 100);
  localparam logic [KV_W-1:0] KV_MAX  = KV_W'(((KV_HUND[0] << FRAC) + 50) / 100);
  localparam logic [LOSS_W-1:0] LOSS_CAP = LOSS_W'(longint'(1) << 62);

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  function automatic logic [LEVEL_W-1:0] sat32(input logic signed [63:0] x);
    logic [LEVEL_W-1:0] r;
    if (x > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = x[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/lock_flow_derivative_kv_interp.sv]
// Canal-lock ODE derivative unit: per sample, upper and lower level rates and the
// flow rate with head drive, valve loss interpolation and quadratic losses.
// Input channel in_t*: one request per sample, fields packed in in_tdata.
// Output channel out_t*: one result per request, in request order.
// Config port cfg_*: one register written per cycle with cfg_we high, no read-back;
// write only while no request is in flight. Indexes above 6 are ignored.
// Throughput: one request per cycle while the output is not stalled, set by the 14-stage
// pipeline (front products, segment search, reciprocal divide of the interpolated loss,
// split loss product).
// Each stage carries a valid bit; a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up while the output waits.
// Stall: out_tdata holds while out_tready is low; in_tready drops only when every
// stage holds a request.
// Reset (rst_n low, synchronous): all stages empty, registers return to defaults
// (gains, head gain, loss scale and opening rate 1.0; friction and entry loss 0).
// Depends on lfd_pkg, lfd_front, lfd_kv_interp, lfd_loss.
`timescale 1ns / 1ps
`default_nettype none

module lock_flow_derivative_kv_interp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // time_elapsed[30:0], upper_level[62:31], lower_level[94:63], flow[126:95], zero pad
  input  logic [lfd_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // upper_rate[31:0], lower_rate[63:32], flow_rate[95:64]
  output logic [lfd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [lfd_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [lfd_pkg::REG_W-1:0]          cfg_wdata
);
  import lfd_pkg::*;

  localparam logic [REG_W-1:0] ONE = REG_W'(1 << FRAC);

  logic [REG_W-1:0] upper_gain_r, lower_gain_r, head_gain_r, pipe_friction_r;
  logic [REG_W-1:0] loss_scale_r, entry_loss_r, opening_rate_r;

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] stage_en;

  logic [PCT_W-1:0]       pct_w;
  logic [SEG_W-1:0]       seg_w;
  side_t                  side_front, side_kv;
  logic [KV_W-1:0]        kv_w;
  logic [LEVEL_W-1:0]     upper_rate, lower_rate, flow_rate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_gain_r    <= ONE;
      lower_gain_r    <= ONE;
      head_gain_r     <= ONE;
      pipe_friction_r <= '0;
      loss_scale_r    <= ONE;
      entry_loss_r    <= '0;
      opening_rate_r  <= ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER_GAIN:    upper_gain_r    <= cfg_wdata;
        REG_LOWER_GAIN:    lower_gain_r    <= cfg_wdata;
        REG_HEAD_GAIN:     head_gain_r     <= cfg_wdata;
        REG_PIPE_FRICTION: pipe_friction_r <= cfg_wdata;
        REG_LOSS_SCALE:    loss_scale_r    <= cfg_wdata;
        REG_ENTRY_LOSS:    entry_loss_r    <= cfg_wdata;
        REG_OPENING_RATE:  opening_rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage moves when any stage from it to the output is empty or the output drains
  genvar g;
  generate
    for (g = 0; g < PIPE_STAGES; g++) begin : g_en
      assign stage_en[g] = out_tready || !(&v_r[PIPE_STAGES-1:g]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (stage_en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_tready  = stage_en[0];
  assign out_tvalid = v_r[PIPE_STAGES-1];

  lfd_front u_front (
    .clk          (clk),
    .stage_en     (stage_en[FRONT_STAGES-1:0]),
    .upper_gain   (upper_gain_r),
    .lower_gain   (lower_gain_r),
    .head_gain    (head_gain_r),
    .opening_rate (opening_rate_r),
    .time_elapsed (in_tdata[30:0]),
    .upper_level  (in_tdata[62:31]),
    .lower_level  (in_tdata[94:63]),
    .flow         (in_tdata[126:95]),
    .pct          (pct_w),
    .seg          (seg_w),
    .side_out     (side_front)
  );

  lfd_kv_interp u_kv (
    .clk      (clk),
    .stage_en (stage_en[FRONT_STAGES+KV_STAGES-1:FRONT_STAGES]),
    .pct      (pct_w),
    .seg      (seg_w),
    .side_in  (side_front),
    .kv       (kv_w),
    .side_out (side_kv)
  );

  lfd_loss u_loss (
    .clk           (clk),
    .stage_en      (stage_en[PIPE_STAGES-1:FRONT_STAGES+KV_STAGES]),
    .pipe_friction (pipe_friction_r),
    .loss_scale    (loss_scale_r),
    .entry_loss    (entry_loss_r),
    .kv            (kv_w),
    .side_in       (side_kv),
    .upper_rate    (upper_rate),
    .lower_rate    (lower_rate),
    .flow_rate     (flow_rate)
  );

  assign out_tdata = {flow_rate, lower_rate, upper_rate};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_tready) |-> !in_tready)
    else $error("request taken while every stage is held");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_tready)
    else $error("input stalled with an empty first stage");

  a_kv_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[KV_OUT_STAGE] |-> (kv_w <= KV_MAX))
    else $error("interpolated valve loss above table maximum");

endmodule

`default_nettype wire

[sv/lfd_front.sv]
// Front stages: gain products, level rates, head drive, Q*|Q| and valve segment search.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_front (
  input  logic                               clk,
  input  logic [lfd_pkg::FRONT_STAGES-1:0]   stage_en,
  input  logic [lfd_pkg::REG_W-1:0]          upper_gain,
  input  logic [lfd_pkg::REG_W-1:0]          lower_gain,
  input  logic [lfd_pkg::REG_W-1:0]          head_gain,
  input  logic [lfd_pkg::REG_W-1:0]          opening_rate,
  input  logic [lfd_pkg::REG_W-1:0]          time_elapsed,
  input  logic signed [lfd_pkg::LEVEL_W-1:0] upper_level,
  input  logic signed [lfd_pkg::LEVEL_W-1:0] lower_level,
  input  logic signed [lfd_pkg::LEVEL_W-1:0] flow,
  output logic [lfd_pkg::PCT_W-1:0]          pct,
  output logic [lfd_pkg::SEG_W-1:0]          seg,
  output lfd_pkg::side_t                     side_out
);
  import lfd_pkg::*;

  logic signed [63:0]         p_up_c, p_lo_c;
  logic [T_PROD_W-1:0]        p_t_c;
  logic signed [LEVEL_W:0]    dh_c;
  logic signed [64:0]         p_d_c;
  logic [LEVEL_W-1:0]         q_mag_c;
  logic [63:0]                p_q_c;

  logic signed [62:0]         p_up_r, p_lo_r;
  logic [T_PROD_W-1:0]        p_t_r;
  logic signed [63:0]         p_d_r;
  logic [62:0]                p_q_r;
  logic                       q_neg_r;

  logic signed [63:0]         up_ext, up_neg, up_sh, lo_ext, lo_sh, d_sh;
  logic [PCT_RAW_W-1:0]       pct_raw;
  logic [SEG_W-1:0]           seg_c;
  side_t                      side_c;

  logic [PCT_W-1:0]           pct_r;
  logic [SEG_W-1:0]           seg_r;
  side_t                      side_r;

  assign p_up_c  = $signed({1'b0, upper_gain}) * flow;
  assign p_lo_c  = $signed({1'b0, lower_gain}) * flow;
  assign p_t_c   = time_elapsed * opening_rate;
  assign dh_c    = upper_level - lower_level;
  assign p_d_c   = $signed({1'b0, head_gain}) * dh_c;
  assign q_mag_c = flow[LEVEL_W-1] ? (32'd0 - flow) : flow;
  assign p_q_c   = q_mag_c * q_mag_c;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p_up_r  <= p_up_c[62:0];
      p_lo_r  <= p_lo_c[62:0];
      p_t_r   <= p_t_c;
      p_d_r   <= p_d_c[63:0];
      p_q_r   <= p_q_c[62:0];
      q_neg_r <= flow[LEVEL_W-1];
    end
  end

  assign up_ext  = {p_up_r[62], p_up_r};
  assign up_neg  = -up_ext;
  assign up_sh   = up_neg >>> FRAC;
  assign lo_ext  = {p_lo_r[62], p_lo_r};
  assign lo_sh   = lo_ext >>> FRAC;
  assign d_sh    = p_d_r >>> FRAC;
  assign pct_raw = p_t_r[T_PROD_W-1:FRAC];

  // clamped opening lands in the last segment
  always_comb begin
    seg_c = '0;
    for (int j = 1; j < TABLE_POINTS; j++) begin
      if (pct_raw >= PCT_RAW_W'(SEG_BP[j])) seg_c = SEG_W'(j);
    end
  end

  always_comb begin
    side_c.upper_rate = sat32(up_sh);
    side_c.lower_rate = sat32(lo_sh);
    side_c.drive      = d_sh[DRIVE_W-1:0];
    side_c.q_neg      = q_neg_r;
    side_c.qq         = p_q_r[62:FRAC];
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      pct_r  <= pct_raw[PCT_W-1:0];
      seg_r  <= seg_c;
      side_r <= side_c;
    end
  end

  assign pct      = pct_r;
  assign seg      = seg_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

[sv/lfd_kv_interp.sv]
// Valve loss interpolation: segment slope product, base add, divide by 125 by reciprocal.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_kv_interp (
  input  logic                           clk,
  input  logic [lfd_pkg::KV_STAGES-1:0]  stage_en,
  input  logic [lfd_pkg::PCT_W-1:0]      pct,
  input  logic [lfd_pkg::SEG_W-1:0]      seg,
  input  lfd_pkg::side_t                 side_in,
  output logic [lfd_pkg::KV_W-1:0]       kv,
  output lfd_pkg::side_t                 side_out
);
  import lfd_pkg::*;

  localparam int XL_W  = 18;
  localparam int XH_W  = X_W - XL_W;
  localparam int PH_W  = XH_W + RECIP_W;
  localparam int PL_W  = XL_W + RECIP_W;
  localparam int SUM_W = PH_W + XL_W;
  localparam int Q0_W  = SUM_W - X_W;

  side_t                  side_r [KV_STAGES];

  logic [PCT_W-1:0]       d_full_c;
  logic [D_W-1:0]         d_c;
  logic signed [DM_W-1:0] dm_c;
  logic signed [DM_W-1:0] dm_r;
  logic [SEG_W-1:0]       seg_a_r;

  logic signed [N_W-1:0]  n_c;
  logic [N_W-1:0]         n_u;
  logic [X_W-1:0]         x_c;
  logic [X_W-1:0]         x_b_r, x_c_r, x_d_r;
  logic                   last_b_r, last_c_r, last_d_r;

  logic [PH_W-1:0]        ph_c, ph_r;
  logic [PL_W-1:0]        pl_c, pl_r;
  logic [SUM_W-1:0]       sum_c;
  logic [Q0_W-1:0]        q0_r;

  logic [X_W:0]           q0_mul_c, rem_c;
  logic [Q0_W-1:0]        q_fix_c;
  logic [KV_W-1:0]        kv_c, kv_r;

  assign d_full_c = pct - SEG_BP[seg];
  assign d_c      = d_full_c[D_W-1:0];
  assign dm_c     = $signed({1'b0, d_c}) * SEG_DEL[seg];

  assign n_c = SEG_BASE[seg_a_r] + dm_r;
  assign n_u = n_c;
  assign x_c = X_W'(n_u >> SEG_SHIFT[seg_a_r]);

  assign ph_c = x_b_r[X_W-1:XL_W] * RECIP;
  assign pl_c = x_b_r[XL_W-1:0] * RECIP;

  assign sum_c = {ph_r, {XL_W{1'b0}}} + SUM_W'(pl_r);

  // estimate is low by at most one
  assign q0_mul_c = q0_r * (X_W + 1)'(KV_DIV);
  assign rem_c    = {1'b0, x_d_r} - q0_mul_c;
  assign q_fix_c  = (rem_c >= (X_W + 1)'(KV_DIV)) ? q0_r + Q0_W'(1) : q0_r;
  assign kv_c     = last_d_r ? KV_FULL : q_fix_c[KV_W-1:0];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dm_r      <= dm_c;
      seg_a_r   <= seg;
      side_r[0] <= side_in;
    end
    if (stage_en[1]) begin
      x_b_r    <= x_c;
      last_b_r <= (seg_a_r == SEG_W'(LAST_SEG));
    end
    if (stage_en[2]) begin
      ph_r     <= ph_c;
      pl_r     <= pl_c;
      x_c_r    <= x_b_r;
      last_c_r <= last_b_r;
    end
    if (stage_en[3]) begin
      q0_r     <= sum_c[SUM_W-1:X_W];
      x_d_r    <= x_c_r;
      last_d_r <= last_c_r;
    end
    if (stage_en[4]) begin
      kv_r <= kv_c;
    end
    for (int i = 1; i < KV_STAGES; i++) begin
      if (stage_en[i]) side_r[i] <= side_r[i-1];
    end
  end

  assign kv       = kv_r;
  assign side_out = side_r[KV_STAGES-1];

endmodule

`default_nettype wire

[sv/lfd_loss.sv]
// Loss stages: coefficient, split 48x47 loss product, cap, and saturated flow rate.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_loss (
  input  logic                            clk,
  input  logic [lfd_pkg::LOSS_STAGES-1:0] stage_en,
  input  logic [lfd_pkg::REG_W-1:0]       pipe_friction,
  input  logic [lfd_pkg::REG_W-1:0]       loss_scale,
  input  logic [lfd_pkg::REG_W-1:0]       entry_loss,
  input  logic [lfd_pkg::KV_W-1:0]        kv,
  input  lfd_pkg::side_t                  side_in,
  output logic [lfd_pkg::LEVEL_W-1:0]     upper_rate,
  output logic [lfd_pkg::LEVEL_W-1:0]     lower_rate,
  output logic [lfd_pkg::LEVEL_W-1:0]     flow_rate
);
  import lfd_pkg::*;

  localparam int EK_W     = 32;
  localparam int SCALED_W = EK_W + REG_W;
  localparam int COEF_W   = SCALED_W - FRAC + 1;
  localparam int HALF_W   = 24;
  localparam int CH_W     = COEF_W - HALF_W;
  localparam int QH_W     = QQ_W - HALF_W;
  localparam int P00_W    = 2 * HALF_W;
  localparam int P01_W    = HALF_W + QH_W;
  localparam int P10_W    = CH_W + HALF_W;
  localparam int P11_W    = CH_W + QH_W;
  localparam int MID_W    = P10_W + 1;
  localparam int FULL_W   = COEF_W + QQ_W;
  localparam int SH_W     = FULL_W - FRAC;

  side_t                 side_r [LOSS_STAGES-1];

  logic [EK_W-1:0]       ek_c;
  logic [SCALED_W-1:0]   scaled_c, scaled_r;
  logic [COEF_W-1:0]     coef_c, coef_r;
  logic [P00_W-1:0]      p00_c, p00_r, p00_m_r;
  logic [P01_W-1:0]      p01_c, p01_r;
  logic [P10_W-1:0]      p10_c, p10_r;
  logic [P11_W-1:0]      p11_c, p11_r, p11_m_r;
  logic [MID_W-1:0]      mid_c, mid_r;
  logic [FULL_W-1:0]     full_c, full_r;
  logic [SH_W-1:0]       sh_c;
  logic [LOSS_W-1:0]     loss_c, loss_r;
  logic signed [63:0]    drv_c, loss_ext_c, fr_c;

  logic [LEVEL_W-1:0]    upper_r, lower_r, flow_r;

  assign ek_c     = EK_W'(entry_loss) + EK_W'(kv);
  assign scaled_c = ek_c * loss_scale;
  assign coef_c   = COEF_W'(pipe_friction) + COEF_W'(scaled_r[SCALED_W-1:FRAC]);

  assign p00_c = coef_r[HALF_W-1:0] * side_r[1].qq[HALF_W-1:0];
  assign p01_c = coef_r[HALF_W-1:0] * side_r[1].qq[QQ_W-1:HALF_W];
  assign p10_c = coef_r[COEF_W-1:HALF_W] * side_r[1].qq[HALF_W-1:0];
  assign p11_c = coef_r[COEF_W-1:HALF_W] * side_r[1].qq[QQ_W-1:HALF_W];

  assign mid_c = MID_W'(p01_r) + MID_W'(p10_r);

  assign full_c = FULL_W'(p00_m_r) + FULL_W'({mid_r, {HALF_W{1'b0}}})
                + {p11_m_r, {(2 * HALF_W){1'b0}}};

  assign sh_c   = full_r[FULL_W-1:FRAC];
  assign loss_c = (sh_c > SH_W'(LOSS_CAP)) ? LOSS_CAP : sh_c[LOSS_W-1:0];

  assign drv_c      = {{(64 - DRIVE_W){side_r[5].drive[DRIVE_W-1]}}, side_r[5].drive};
  assign loss_ext_c = {1'b0, loss_r};
  assign fr_c       = side_r[5].q_neg ? drv_c + loss_ext_c : drv_c - loss_ext_c;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      scaled_r  <= scaled_c;
      side_r[0] <= side_in;
    end
    if (stage_en[1]) begin
      coef_r <= coef_c;
    end
    if (stage_en[2]) begin
      p00_r <= p00_c;
      p01_r <= p01_c;
      p10_r <= p10_c;
      p11_r <= p11_c;
    end
    if (stage_en[3]) begin
      p00_m_r <= p00_r;
      mid_r   <= mid_c;
      p11_m_r <= p11_r;
    end
    if (stage_en[4]) begin
      full_r <= full_c;
    end
    if (stage_en[5]) begin
      loss_r <= loss_c;
    end
    if (stage_en[6]) begin
      upper_r <= side_r[5].upper_rate;
      lower_r <= side_r[5].lower_rate;
      flow_r  <= sat32(fr_c);
    end
    for (int i = 1; i < LOSS_STAGES - 1; i++) begin
      if (stage_en[i]) side_r[i] <= side_r[i-1];
    end
  end

  assign upper_rate = upper_r;
  assign lower_rate = lower_r;
  assign flow_rate  = flow_r;

endmodule

`default_nettype wire
